// ===== sv/pdls_pkg.sv =====
package pdls_pkg;

  // Input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_PATTERN_MODE = 2'd0;
  localparam logic [1:0] REG_PIXEL_COLOR  = 2'd1;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

  // Pattern modes; undefined codes fall back to solid
  localparam logic [2:0] MODE_SOLID   = 3'd0;
  localparam logic [2:0] MODE_DOTTED  = 3'd1;
  localparam logic [2:0] MODE_DASHED  = 3'd2;
  localparam logic [2:0] MODE_DASHDOT = 3'd3;
  localparam logic [2:0] MODE_THICK   = 3'd4;

  localparam logic [3:0] PHASE_LAST    = 4'd9;
  localparam logic [3:0] DASH_LEN      = 4'd5;
  localparam logic [3:0] DOT_PHASE     = 4'd7;
  localparam logic [2:0] THICK_LAST    = 3'd4;

  localparam logic [2:0]  RST_PATTERN_MODE = MODE_SOLID;
  localparam logic [23:0] RST_PIXEL_COLOR  = 24'hFFFFFF;
  localparam logic [11:0] RST_FRAME_WIDTH  = 12'd1181;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd701;

  typedef struct packed {
    logic       start;      // load endpoints, set up division
    logic       div_step;   // one quotient bit per axis
    logic       emit;       // load result register for slot
    logic       emit_idle;  // load the idle response
    logic       advance;    // move to the next step of the line
    logic [2:0] slot;
  } pdls_cmd_t;

  typedef struct packed {
    logic line_active;
    logic thick;
    logic out_last;
  } pdls_sts_t;

  // Pixel offsets of the five thick-mode results, centre first
  function automatic logic [3:0] off_x(input logic [2:0] slot);
    logic [3:0] r;
    case (slot)
      3'd1:    r = 4'd11;
      3'd2:    r = 4'd9;
      3'd3:    r = 4'd11;
      3'd4:    r = 4'd9;
      default: r = 4'd10;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] off_y(input logic [2:0] slot);
    logic [3:0] r;
    case (slot)
      3'd1:    r = 4'd9;
      3'd2:    r = 4'd11;
      3'd3:    r = 4'd11;
      3'd4:    r = 4'd9;
      default: r = 4'd10;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/pdls_ctrl.sv =====
module pdls_ctrl import pdls_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      opcode_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  pdls_sts_t sts_i,
  output pdls_cmd_t cmd_o
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } ctl_state_e;

  ctl_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]       slot_q, slot_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    slot_d  = slot_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_START) begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = ST_DIV;
          end else if (!sts_i.line_active) begin
            cmd_o.emit_idle = 1'b1;
            state_d         = ST_OUT;
          end else begin
            cmd_o.emit    = 1'b1;
            cmd_o.slot    = '0;
            cmd_o.advance = !sts_i.thick;
            slot_d        = 3'd1;
            state_d       = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (sts_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            // next neighbor of a thick step
            cmd_o.emit    = 1'b1;
            cmd_o.slot    = slot_q;
            cmd_o.advance = (slot_q == THICK_LAST);
            slot_d        = slot_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      slot_q  <= slot_d;
    end
  end

endmodule

// ===== sv/pdls_datapath.sv =====
module pdls_datapath import pdls_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pdls_cmd_t             cmd_i,
  output pdls_sts_t             sts_o,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [23:0]           cfg_data_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [23:0]           color_o,
  output logic                  plot_o,
  output logic                  last_of_step_o,
  output logic                  line_done_o
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int PW   = C + F + 2;         // position width
  localparam int VW   = PW + 1;            // position minus offset
  localparam int TW   = VW - F;            // truncated coordinate
  localparam int IW   = F + 2;             // increment width
  localparam int CMPW = (TW > 13) ? TW : 13;
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  // configuration
  logic [2:0]  mode_q;
  logic [23:0] color_q;
  logic [11:0] fw_q, fh_q;

  // line state
  logic [PW-1:0] pos_x_q, pos_y_q;
  logic [C-1:0]  len_q, step_q;
  logic [3:0]    phase_q;
  logic          active_q;

  // divider
  logic [C:0]    rx_q, ry_q;
  logic [F:0]    qx_q, qy_q;
  logic          negx_q, negy_q, zero_q;

  // result register
  logic [C-1:0]  px_q, py_q;
  logic [23:0]   ocolor_q;
  logic          plot_q, last_q, done_q;

  // start set-up
  logic [C:0]    dx, dy;
  logic [C-1:0]  ax, ay, len_d;
  logic [PW-1:0] hx, hy;

  always_comb begin
    dx    = {1'b0, x_end_i} - {1'b0, x_start_i};
    dy    = {1'b0, y_end_i} - {1'b0, y_start_i};
    ax    = dx[C] ? C'(-dx) : dx[C-1:0];
    ay    = dy[C] ? C'(-dy) : dy[C-1:0];
    len_d = (ax > ay) ? ax : ay;
    hx    = (dx == '0) ? '0 : (dx[C] ? -HALF : HALF);
    hy    = (dy == '0) ? '0 : (dy[C] ? -HALF : HALF);
  end

  // restoring division, one bit per cycle
  logic         bx, by;
  logic [C:0]   rx_n, ry_n;

  always_comb begin
    bx   = (rx_q >= {1'b0, len_q});
    by   = (ry_q >= {1'b0, len_q});
    rx_n = bx ? (rx_q - {1'b0, len_q}) : rx_q;
    ry_n = by ? (ry_q - {1'b0, len_q}) : ry_q;
  end

  logic [IW-1:0] inc_x, inc_y;

  always_comb begin
    inc_x = zero_q ? '0 : (negx_q ? -{1'b0, qx_q} : {1'b0, qx_q});
    inc_y = zero_q ? '0 : (negy_q ? -{1'b0, qy_q} : {1'b0, qy_q});
  end

  // pixel for the selected slot
  logic [VW-1:0]   offx_v, offy_v, vx, vy;
  logic [TW-1:0]   tx, ty;
  logic            in_frame, hit, done, thick;

  always_comb begin
    offx_v   = VW'({off_x(cmd_i.slot), {F{1'b0}}});
    offy_v   = VW'({off_y(cmd_i.slot), {F{1'b0}}});
    vx       = {pos_x_q[PW-1], pos_x_q} - offx_v;
    vy       = {pos_y_q[PW-1], pos_y_q} - offy_v;
    // floor plus one for negative values with a fraction: round toward zero
    tx       = vx[VW-1:F] + TW'(vx[VW-1] & (|vx[F-1:0]));
    ty       = vy[VW-1:F] + TW'(vy[VW-1] & (|vy[F-1:0]));
    in_frame = !tx[TW-1] && !ty[TW-1] &&
               (CMPW'(tx) < CMPW'(fw_q)) && (CMPW'(ty) < CMPW'(fh_q));
    thick    = (mode_q == MODE_THICK);
    done     = (step_q == len_q);
    case (mode_q)
      MODE_DOTTED:  hit = (step_q[1:0] == 2'b00);
      MODE_DASHED:  hit = (phase_q < DASH_LEN);
      MODE_DASHDOT: hit = (phase_q < DASH_LEN) || (phase_q == DOT_PHASE);
      default:      hit = 1'b1;
    endcase
  end

  assign sts_o.line_active = active_q;
  assign sts_o.thick       = thick;
  assign sts_o.out_last    = last_q;

  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign color_o        = ocolor_q;
  assign plot_o         = plot_q;
  assign last_of_step_o = last_q;
  assign line_done_o    = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RST_PATTERN_MODE;
      color_q  <= RST_PIXEL_COLOR;
      fw_q     <= RST_FRAME_WIDTH;
      fh_q     <= RST_FRAME_HEIGHT;
      active_q <= 1'b0;
      step_q   <= '0;
      phase_q  <= '0;
      len_q    <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      zero_q   <= 1'b1;
      last_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PATTERN_MODE: mode_q  <= cfg_data_i[2:0];
          REG_PIXEL_COLOR:  color_q <= cfg_data_i;
          REG_FRAME_WIDTH:  fw_q    <= cfg_data_i[11:0];
          REG_FRAME_HEIGHT: fh_q    <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        pos_x_q  <= {2'b00, x_start_i, {F{1'b0}}} + hx;
        pos_y_q  <= {2'b00, y_start_i, {F{1'b0}}} + hy;
        len_q    <= len_d;
        zero_q   <= (len_d == '0);
        step_q   <= '0;
        phase_q  <= '0;
        active_q <= 1'b1;
      end else if (cmd_i.advance) begin
        pos_x_q <= pos_x_q + {{C{inc_x[IW-1]}}, inc_x};
        pos_y_q <= pos_y_q + {{C{inc_y[IW-1]}}, inc_y};
        step_q  <= step_q + 1'b1;
        phase_q <= (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
        if (done) begin
          active_q <= 1'b0;
        end
      end
      if (cmd_i.emit) begin
        last_q <= !thick || (cmd_i.slot == THICK_LAST);
      end else if (cmd_i.emit_idle) begin
        last_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rx_q   <= {1'b0, ax};
      ry_q   <= {1'b0, ay};
      negx_q <= dx[C];
      negy_q <= dy[C];
    end else if (cmd_i.div_step) begin
      rx_q <= {rx_n[C-1:0], 1'b0};
      ry_q <= {ry_n[C-1:0], 1'b0};
      qx_q <= {qx_q[F-1:0], bx};
      qy_q <= {qy_q[F-1:0], by};
    end
    if (cmd_i.emit) begin
      px_q     <= tx[C-1:0];
      py_q     <= ty[C-1:0];
      ocolor_q <= color_q;
      plot_q   <= hit && in_frame;
      done_q   <= done;
    end else if (cmd_i.emit_idle) begin
      px_q     <= '0;
      py_q     <= '0;
      ocolor_q <= color_q;
      plot_q   <= 1'b0;
      done_q   <= 1'b1;
    end
  end

endmodule

// ===== sv/patterned_dda_line_stepper.sv =====
// Channel   Direction  Handshake                 Payload
// in        request    in_valid_i / in_stall_o   opcode, x_start, y_start, x_end, y_end
// out       result     out_valid_o / out_stall_i pixel_x, pixel_y, color, plot,
//                                                last_of_step, line_done
// cfg       write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A step request gives one result, or five in thick mode: the block accepts it and
// then loads each result in turn into the output register.
// A start request runs the bit-serial divider that forms both increments in
// parallel, one quotient bit per cycle.
// Reset returns to idle with the configuration at its reset values.
// A stalled result holds the output register and the block takes no new request.
module patterned_dda_line_stepper import pdls_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [23:0]           color_o,
  output logic                  plot_o,
  output logic                  last_of_step_o,
  output logic                  line_done_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [23:0]           cfg_data_i
);

  pdls_cmd_t cmd;
  pdls_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pdls_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdls_datapath #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .color_o       (color_o),
    .plot_o        (plot_o),
    .last_of_step_o(last_of_step_o),
    .line_done_o   (line_done_o)
  );

endmodule

// ===== sv/pdls_checker.sv =====
module pdls_checker import pdls_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  opcode_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COORD_BITS-1:0] pixel_x_o,
  input logic [COORD_BITS-1:0] pixel_y_o,
  input logic                  plot_o,
  input logic                  last_of_step_o
);

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o) &&
    $stable(pixel_y_o) && $stable(plot_o) && $stable(last_of_step_o))
    else $error("stalled result changed");

  // no request taken while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while result pending");

  a_step_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_STEP) |=> out_valid_o)
    else $error("step request gave no result");

  a_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_START) |=> in_stall_o && !out_valid_o)
    else $error("start request not busy dividing");

  a_step_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_of_step_o |=> out_valid_o)
    else $error("step ended without last result");

endmodule

bind patterned_dda_line_stepper pdls_checker #(
  .COORD_BITS(COORD_BITS)
) u_pdls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .opcode_i      (opcode_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .plot_o        (plot_o),
  .last_of_step_o(last_of_step_o)
);
